// ===== rtl/modular_exponentiation_assert.svh =====
// Assertion macros used by the checker file.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MODEXP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("modexp assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MODEXP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("modexp assertion failed");

`endif

// ===== rtl/modexp_pkg.sv =====
package modexp_pkg;

  typedef struct packed {
    logic start;
  } mmul_ctl_t;

  typedef struct packed {
    logic done;
  } mmul_sts_t;

endpackage

// ===== rtl/modular_exponentiation.sv =====
// Modular exponentiation, base_value_i ** exponent_i mod modulus.
// Input channel: base_value_i and exponent_i, transfer on in_valid_i & in_ready_o.
// Output channel: power_mod_o, transfer on out_valid_o & out_ready_i.
// Modulus is written over the APB-style port with paddr[2] low; the user must write it
// only while the block is idle, which the block itself does not enforce. Modulus 0
// makes all arithmetic wrap modulo 2**DATA_WIDTH. One item at a time: two bit-serial
// modular multipliers, one for the square and one for the multiply. The base is reduced
// first, then for each exponent bit up to the highest set one a step state starts a
// square and a multiply that run side by side. For exponent zero the result is one.
// in_ready_o rises together with out_valid_o.
// A finished result sits in an output register; the next item is taken while it
// waits. If the receiver still stalls when the following result is ready, the
// block holds that result and accepts nothing until the register frees.
// Reset clears the modulus to 1 and empties the output register.
module modular_exponentiation import modexp_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned EXP_WIDTH  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DATA_WIDTH-1:0] base_value_i,
  input  logic [EXP_WIDTH-1:0]  exponent_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] power_mod_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [DATA_WIDTH-1:0] One = DATA_WIDTH'(1);

  logic [2:0]            state_q;
  logic [2:0]            state_d;
  logic [DATA_WIDTH-1:0] modulus_q;
  logic [DATA_WIDTH-1:0] acc_q;
  logic [DATA_WIDTH-1:0] b_q;
  logic [EXP_WIDTH-1:0]  e_q;
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] power_mod_q;
  logic                  in_xfer;
  logic                  out_free;
  logic                  cfg_wr;

  mmul_ctl_t             ctl_a;
  mmul_ctl_t             ctl_b;
  mmul_sts_t             sts_a;
  mmul_sts_t             sts_b;
  logic [DATA_WIDTH-1:0] mult_a;
  logic [DATA_WIDTH-1:0] addend_a;
  logic [DATA_WIDTH-1:0] res_a;
  logic [DATA_WIDTH-1:0] res_b;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && !paddr[2];
  assign prdata   = paddr[2] ? 32'd0 : 32'(modulus_q);

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign ctl_a.start = in_xfer || ((state_q == S_STEP) && (e_q != '0));
  assign ctl_b.start = (state_q == S_STEP) && (e_q != '0);
  assign mult_a      = (state_q == S_IDLE) ? base_value_i : acc_q;
  assign addend_a    = (state_q == S_RED) ? One : b_q;

  modexp_mmul #(.W(DATA_WIDTH)) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_a),
    .mult_i    (mult_a),
    .addend_i  (addend_a),
    .modulus_i (modulus_q),
    .result_o  (res_a),
    .sts_o     (sts_a)
  );

  modexp_mmul #(.W(DATA_WIDTH)) u_sqr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_b),
    .mult_i    (b_q),
    .addend_i  (b_q),
    .modulus_i (modulus_q),
    .result_o  (res_b),
    .sts_o     (sts_b)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = S_RED;
      end
      S_RED: begin
        if (sts_a.done) state_d = S_STEP;
      end
      S_STEP: begin
        state_d = (e_q == '0) ? S_DONE : S_RUN;
      end
      S_RUN: begin
        if (sts_a.done && sts_b.done) state_d = S_STEP;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      modulus_q   <= One;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) modulus_q <= pwdata[DATA_WIDTH-1:0];
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      e_q   <= exponent_i;
      acc_q <= One;
    end
    if ((state_q == S_RED) && sts_a.done) begin
      b_q <= res_a;
    end
    if ((state_q == S_RUN) && sts_a.done && sts_b.done) begin
      if (e_q[0]) acc_q <= res_a;
      b_q <= res_b;
      e_q <= e_q >> 1;
    end
    if ((state_q == S_DONE) && out_free) begin
      power_mod_q <= acc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign power_mod_o = power_mod_q;

endmodule

// ===== rtl/modexp_mmul.sv =====
module modexp_mmul import modexp_pkg::*; #(
  parameter int unsigned W = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  mmul_ctl_t    ctl_i,
  input  logic [W-1:0] mult_i,
  input  logic [W-1:0] addend_i,
  input  logic [W-1:0] modulus_i,
  output logic [W-1:0] result_o,
  output mmul_sts_t    sts_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  sh_q;
  logic [W-1:0]  r_q;
  logic [W-1:0]  r_d;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [W+1:0]  t;
  logic [W+1:0]  m1;
  logic [W+1:0]  m2;
  logic [W+1:0]  d1;
  logic [W+1:0]  d2;

  // double the partial remainder, add the addend if the bit is set, fold back
  always_comb begin
    t  = {1'b0, r_q, 1'b0} + {2'b00, (sh_q[W-1] ? addend_i : {W{1'b0}})};
    m1 = {2'b00, modulus_i};
    m2 = {1'b0, modulus_i, 1'b0};
    d1 = t - m1;
    d2 = t - m2;
    if (modulus_i == '0) begin
      r_d = t[W-1:0];
    end else if (t >= m2) begin
      r_d = d2[W-1:0];
    end else if (t >= m1) begin
      r_d = d1[W-1:0];
    end else begin
      r_d = t[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      sh_q <= mult_i;
      r_q  <= '0;
    end else if (busy_q) begin
      sh_q <= {sh_q[W-2:0], 1'b0};
      r_q  <= r_d;
    end
  end

  assign result_o   = r_q;
  assign sts_o.done = done_q;

endmodule

// ===== rtl/modexp_chk.sv =====
`include "modular_exponentiation_assert.svh"

module modexp_chk #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned EXP_WIDTH  = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [2:0]            paddr,
  input logic [31:0]           pwdata,
  input logic [31:0]           prdata,
  input logic                  pready,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic [DATA_WIDTH-1:0] base_value_i,
  input logic [EXP_WIDTH-1:0]  exponent_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [DATA_WIDTH-1:0] power_mod_o
);

  logic in_xfer;
  logic cfg_wr0;

  assign in_xfer = in_valid_i && in_ready_o;
  assign cfg_wr0 = psel && penable && pwrite && pready && !paddr[2];

  `MODEXP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(power_mod_o))

  `MODEXP_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o,
    in_valid_i && $stable(base_value_i) && $stable(exponent_i))

  `MODEXP_ASSERT_NEXT(a_busy_after_in, in_xfer, !in_ready_o)

  `MODEXP_ASSERT_NEXT(a_no_instant_result, in_xfer, !$rose(out_valid_o))

  `MODEXP_ASSERT_NEXT(a_modulus_readback, cfg_wr0 && !paddr[2],
    (paddr[2] == 1'b1) || (prdata[DATA_WIDTH-1:0] == $past(pwdata[DATA_WIDTH-1:0])))

endmodule

bind modular_exponentiation modexp_chk #(
  .DATA_WIDTH (DATA_WIDTH),
  .EXP_WIDTH  (EXP_WIDTH)
) u_chk (.*);
